@@ hw/rtl/blink_code_error_indicator_top_defines.svh @@
// Assertion macros for the blink code error indicator.
// Used by the RTL modules that carry concurrent checks; expects clk_i and rst_ni in scope.
`ifndef BLINK_CODE_ERROR_INDICATOR_TOP_DEFINES_SVH
`define BLINK_CODE_ERROR_INDICATOR_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define BCI_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bci check failed");

// Next-cycle implication, checked out of reset.
`define BCI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bci check failed");

`endif

@@ hw/rtl/bci_pkg.sv @@
// Shared types, constants and helpers for the blink code error indicator.
// No dependencies; used by every other RTL source file except the assertion macros header.
`timescale 1ns / 1ps

package bci_pkg;

  localparam int unsigned CodeW  = 7;
  localparam int unsigned DigitW = 4;
  localparam int unsigned MsW    = 12;
  localparam int unsigned PhaseW = 3;

  localparam logic [MsW-1:0] LONG_MS      = 12'd500;
  localparam logic [MsW-1:0] SHORT_MS     = 12'd250;
  localparam logic [MsW-1:0] DIGIT_GAP_MS = 12'd250;
  localparam logic [MsW-1:0] CODE_GAP_MS  = 12'd3000;

  localparam logic [CodeW-1:0] CODE_MAX = 7'd99;

  // Reported phase codes
  localparam logic [PhaseW-1:0] PH_IDLE  = 3'd0;
  localparam logic [PhaseW-1:0] PH_TENS  = 3'd1;
  localparam logic [PhaseW-1:0] PH_DGAP  = 3'd2;
  localparam logic [PhaseW-1:0] PH_UNITS = 3'd3;
  localparam logic [PhaseW-1:0] PH_CGAP  = 3'd4;

  typedef enum logic {
    REG_ERROR_CODE = 1'b0,
    REG_ENABLE     = 1'b1
  } reg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_TENS  = 5'b00010,
    ST_DGAP  = 5'b00100,
    ST_UNITS = 5'b01000,
    ST_CGAP  = 5'b10000
  } state_e;

  typedef struct packed {
    logic              enable;
    logic [DigitW-1:0] tens;
    logic [DigitW-1:0] units;
  } cfg_t;

  typedef struct packed {
    logic              led_level;
    logic [PhaseW-1:0] phase;
    logic              repeat_done;
  } result_t;

  // Tens digit of a code up to 99: x*205 >> 11 is exact for x below 1029
  function automatic logic [DigitW-1:0] tens_of(input logic [CodeW-1:0] code);
    logic [CodeW+7:0] prod;
    prod = {8'd0, code} * 15'd205;
    return prod[14:11];
  endfunction

  function automatic logic [DigitW-1:0] units_of(input logic [CodeW-1:0] code,
                                                 input logic [DigitW-1:0] tens);
    logic [CodeW-1:0] rem;
    rem = code - ({3'd0, tens} * 7'd10);
    return rem[DigitW-1:0];
  endfunction

  function automatic logic [PhaseW-1:0] phase_of(input state_e st);
    logic [PhaseW-1:0] ph;
    unique case (st)
      ST_IDLE:  ph = PH_IDLE;
      ST_TENS:  ph = PH_TENS;
      ST_DGAP:  ph = PH_DGAP;
      ST_UNITS: ph = PH_UNITS;
      ST_CGAP:  ph = PH_CGAP;
      default:  ph = PH_IDLE;
    endcase
    return ph;
  endfunction

endpackage

@@ hw/rtl/bci_if.sv @@
// Valid/ready channel interfaces for the blink code error indicator.
// Depends on bci_pkg for the phase width.
`timescale 1ns / 1ps

interface bci_in_if;
  logic valid;
  logic ready;
  logic advance;

  modport source (output valid, output advance, input ready);
  modport sink   (input valid, input advance, output ready);
endinterface

interface bci_out_if;
  logic                         valid;
  logic                         ready;
  logic                         led_level;
  logic [bci_pkg::PhaseW-1:0]   phase;
  logic                         repeat_done;

  modport source (output valid, output led_level, output phase, output repeat_done,
                  input ready);
  modport sink   (input valid, input led_level, input phase, input repeat_done,
                  output ready);
endinterface

@@ hw/rtl/bci_cfg.sv @@
// Configuration registers: clamped error code, split into digits, and enable.
// Depends on bci_pkg.
`timescale 1ns / 1ps

module bci_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [bci_pkg::CodeW-1:0]    cfg_data_i,
  output bci_pkg::cfg_t                cfg_o
);

  logic [bci_pkg::CodeW-1:0]  code_clamped;
  logic [bci_pkg::DigitW-1:0] tens_w;
  logic [bci_pkg::DigitW-1:0] units_w;
  bci_pkg::cfg_t              cfg_d, cfg_q;
  bci_pkg::reg_idx_e          idx;

  assign idx          = bci_pkg::reg_idx_e'(cfg_idx_i);
  assign code_clamped = (cfg_data_i > bci_pkg::CODE_MAX) ? bci_pkg::CODE_MAX : cfg_data_i;
  assign tens_w       = bci_pkg::tens_of(code_clamped);
  assign units_w      = bci_pkg::units_of(code_clamped, tens_w);

  // Keep the code as digits so a repetition start only copies them
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (idx)
        bci_pkg::REG_ERROR_CODE: begin
          cfg_d.tens  = tens_w;
          cfg_d.units = units_w;
        end
        bci_pkg::REG_ENABLE: cfg_d.enable = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hw/rtl/bci_core.sv @@
// Blink sequencer: phase, millisecond and blink counters, LED level.
// Depends on bci_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "blink_code_error_indicator_top_defines.svh"

module bci_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  bci_pkg::cfg_t    cfg_i,
  output bci_pkg::result_t res_o
);

  bci_pkg::state_e             state_d, state_q;
  logic [bci_pkg::MsW-1:0]     ms_d, ms_q;
  logic [bci_pkg::DigitW-1:0]  blink_d, blink_q;
  logic                        lit_d, lit_q;
  logic [bci_pkg::DigitW-1:0]  tens_d, tens_q;
  logic [bci_pkg::DigitW-1:0]  units_d, units_q;
  logic [bci_pkg::MsW:0]       ms_inc;
  logic [bci_pkg::DigitW-1:0]  blink_inc;
  logic                        done;
  logic                        start;

  assign ms_inc    = {1'b0, ms_q} + {{bci_pkg::MsW{1'b0}}, 1'b1};
  assign blink_inc = blink_q + {{(bci_pkg::DigitW-1){1'b0}}, 1'b1};

  always_comb begin
    state_d = state_q;
    ms_d    = ms_q;
    blink_d = blink_q;
    lit_d   = lit_q;
    tens_d  = tens_q;
    units_d = units_q;
    done    = 1'b0;
    start   = 1'b0;
    if (step_i) begin
      unique case (state_q)
        bci_pkg::ST_TENS: begin
          if (ms_inc >= {1'b0, bci_pkg::LONG_MS}) begin
            ms_d = '0;
            if (lit_q) begin
              lit_d = 1'b0;
            end else begin
              blink_d = blink_inc;
              if (blink_inc >= tens_q) begin
                state_d = bci_pkg::ST_DGAP;
                lit_d   = 1'b0;
              end else begin
                lit_d = 1'b1;
              end
            end
          end else begin
            ms_d = ms_inc[bci_pkg::MsW-1:0];
          end
        end
        bci_pkg::ST_DGAP: begin
          if (ms_inc >= {1'b0, bci_pkg::DIGIT_GAP_MS}) begin
            ms_d    = '0;
            blink_d = '0;
            if (units_q != '0) begin
              state_d = bci_pkg::ST_UNITS;
              lit_d   = 1'b1;
            end else begin
              state_d = bci_pkg::ST_CGAP;
              lit_d   = 1'b0;
            end
          end else begin
            ms_d = ms_inc[bci_pkg::MsW-1:0];
          end
        end
        bci_pkg::ST_UNITS: begin
          if (ms_inc >= {1'b0, bci_pkg::SHORT_MS}) begin
            ms_d = '0;
            if (lit_q) begin
              lit_d = 1'b0;
            end else begin
              blink_d = blink_inc;
              if (blink_inc >= units_q) begin
                state_d = bci_pkg::ST_CGAP;
                lit_d   = 1'b0;
              end else begin
                lit_d = 1'b1;
              end
            end
          end else begin
            ms_d = ms_inc[bci_pkg::MsW-1:0];
          end
        end
        bci_pkg::ST_CGAP: begin
          if (ms_inc >= {1'b0, bci_pkg::CODE_GAP_MS}) begin
            done  = 1'b1;
            start = 1'b1;
          end else begin
            ms_d = ms_inc[bci_pkg::MsW-1:0];
          end
        end
        bci_pkg::ST_IDLE: start = 1'b1;
        default:          start = 1'b1;
      endcase
    end

    // Start a repetition: latch digits, or drop back to idle when disabled
    if (start) begin
      ms_d    = '0;
      blink_d = '0;
      if (cfg_i.enable) begin
        tens_d  = cfg_i.tens;
        units_d = cfg_i.units;
        if (cfg_i.tens != '0) begin
          state_d = bci_pkg::ST_TENS;
          lit_d   = 1'b1;
        end else begin
          state_d = bci_pkg::ST_DGAP;
          lit_d   = 1'b0;
        end
      end else begin
        state_d = bci_pkg::ST_IDLE;
        lit_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bci_pkg::ST_IDLE;
      ms_q    <= '0;
      blink_q <= '0;
      lit_q   <= 1'b0;
      tens_q  <= '0;
      units_q <= '0;
    end else begin
      state_q <= state_d;
      ms_q    <= ms_d;
      blink_q <= blink_d;
      lit_q   <= lit_d;
      tens_q  <= tens_d;
      units_q <= units_d;
    end
  end

  assign res_o.led_level   = lit_d;
  assign res_o.phase       = bci_pkg::phase_of(state_d);
  assign res_o.repeat_done = done;

  `BCI_ASSERT_NOW(a_dark_outside_blinks,
                  (state_q != bci_pkg::ST_TENS) && (state_q != bci_pkg::ST_UNITS), !lit_q)
  `BCI_ASSERT_NOW(a_tens_count_below_digit, state_q == bci_pkg::ST_TENS, blink_q < tens_q)
  `BCI_ASSERT_NOW(a_units_count_below_digit, state_q == bci_pkg::ST_UNITS, blink_q < units_q)
  `BCI_ASSERT_NOW(a_done_only_from_code_gap, done, step_i && (state_q == bci_pkg::ST_CGAP))
  `BCI_ASSERT_NEXT(a_hold_without_step, !step_i,
                   $stable(state_q) && $stable(ms_q) && $stable(blink_q) && $stable(lit_q))

endmodule

@@ hw/rtl/blink_code_error_indicator_top.sv @@
// A result is held in the output register from the cycle after its tick transaction is taken.
// Throughput: one tick transaction per cycle while the result side keeps ready high.
// The output register lets a new tick in whenever it is empty or being emptied.
// Reset (async, active low) clears the config and sequencer registers, the sequencer to idle
// with the LED dark, and marks the output register empty; its payload is not reset.
// Top level: config registers, blink sequencer and output register; uses bci_pkg, bci_if.
`timescale 1ns / 1ps

module blink_code_error_indicator_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  bci_in_if.sink                    in_i,
  bci_out_if.source                 out_o,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [bci_pkg::CodeW-1:0] cfg_data_i
);

  bci_pkg::cfg_t    cfg;
  bci_pkg::result_t res;
  bci_pkg::result_t res_q;
  logic             out_valid_q;
  logic             accept;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  bci_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  bci_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (accept && in_i.advance),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Payload only: load on each tick transaction
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.led_level   = res_q.led_level;
  assign out_o.phase       = res_q.phase;
  assign out_o.repeat_done = res_q.repeat_done;

endmodule

@@ sim/tb_blink_code_error_indicator_top.sv @@
// Self-checking testbench for the blink code error indicator top level.
// Drives millisecond ticks, predicts LED level, phase and repeat_done per tick transaction.
// Depends on bci_pkg, bci_if and blink_code_error_indicator_top.
`timescale 1ns / 1ps

module tb_blink_code_error_indicator_top;

  localparam int unsigned CLK_PERIOD   = 10;
  localparam int unsigned STALL_LIMIT  = 1000;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned MAX_REPORTS  = 40;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                      cfg_we;
  logic                      cfg_idx;
  logic [bci_pkg::CodeW-1:0] cfg_data;

  bci_in_if  tick_if ();
  bci_out_if led_if ();

  blink_code_error_indicator_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (tick_if),
    .out_o      (led_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Pending ticks and indicator states still owed by the block
  logic             ms_ticks[$];
  bci_pkg::result_t due_results[$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned err_count    = 0;
  int unsigned checked_cnt  = 0;
  int unsigned stall_cycles = 0;

  // Sequencer shadow state and shadow registers
  logic [bci_pkg::PhaseW-1:0] ph_q;
  logic [bci_pkg::MsW-1:0]    ms_q;
  logic [bci_pkg::DigitW-1:0] blinks_q;
  logic                       lit_q;
  logic [bci_pkg::DigitW-1:0] tens_q;
  logic [bci_pkg::DigitW-1:0] units_q;
  logic [bci_pkg::CodeW-1:0]  code_q;
  logic                       en_q;

  function automatic void enter_digit(input logic [bci_pkg::PhaseW-1:0] digit_ph,
                                      input logic [bci_pkg::DigitW-1:0] digit,
                                      input logic [bci_pkg::PhaseW-1:0] skip_ph);
    ms_q     = '0;
    blinks_q = '0;
    if (digit != '0) begin
      ph_q  = digit_ph;
      lit_q = 1'b1;
    end else begin
      ph_q  = skip_ph;
      lit_q = 1'b0;
    end
  endfunction

  // Latch both digits at the start of a repetition, or drop to idle
  function automatic void start_code();
    if (en_q) begin
      tens_q  = bci_pkg::DigitW'(code_q / 10);
      units_q = bci_pkg::DigitW'(code_q % 10);
      enter_digit(bci_pkg::PH_TENS, tens_q, bci_pkg::PH_DGAP);
    end else begin
      ph_q     = bci_pkg::PH_IDLE;
      ms_q     = '0;
      blinks_q = '0;
      lit_q    = 1'b0;
    end
  endfunction

  function automatic logic blink_done(input logic [bci_pkg::MsW-1:0] half_ms,
                                      input logic [bci_pkg::DigitW-1:0] digit);
    logic done;
    done = 1'b0;
    if (int'(ms_q) + 1 >= int'(half_ms)) begin
      ms_q = '0;
      if (lit_q) begin
        lit_q = 1'b0;
      end else begin
        blinks_q = blinks_q + 1'b1;
        if (blinks_q >= digit) done = 1'b1;
        else lit_q = 1'b1;
      end
    end else begin
      ms_q = ms_q + 1'b1;
    end
    return done;
  endfunction

  function automatic logic gap_done(input logic [bci_pkg::MsW-1:0] len_ms);
    if (int'(ms_q) + 1 >= int'(len_ms)) begin
      ms_q = '0;
      return 1'b1;
    end
    ms_q = ms_q + 1'b1;
    return 1'b0;
  endfunction

  function automatic bci_pkg::result_t next_indicator(input logic adv);
    bci_pkg::result_t res;
    logic             rep_end;
    rep_end = 1'b0;
    if (adv) begin
      case (ph_q)
        bci_pkg::PH_TENS: begin
          if (blink_done(bci_pkg::LONG_MS, tens_q)) begin
            ph_q  = bci_pkg::PH_DGAP;
            lit_q = 1'b0;
            ms_q  = '0;
          end
        end
        bci_pkg::PH_DGAP: begin
          if (gap_done(bci_pkg::DIGIT_GAP_MS))
            enter_digit(bci_pkg::PH_UNITS, units_q, bci_pkg::PH_CGAP);
        end
        bci_pkg::PH_UNITS: begin
          if (blink_done(bci_pkg::SHORT_MS, units_q)) begin
            ph_q  = bci_pkg::PH_CGAP;
            lit_q = 1'b0;
            ms_q  = '0;
          end
        end
        bci_pkg::PH_CGAP: begin
          if (gap_done(bci_pkg::CODE_GAP_MS)) begin
            rep_end = 1'b1;
            start_code();
          end
        end
        default: start_code();
      endcase
    end
    res.led_level   = lit_q;
    res.phase       = ph_q;
    res.repeat_done = rep_end;
    return res;
  endfunction

  function automatic void set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endfunction

  task automatic report_mismatch(input string msg);
    if (err_count < MAX_REPORTS) $display("MISMATCH at %0t ns: %s", $time, msg);
    err_count++;
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (ms_ticks.size() != 0 || tick_if.valid || due_results.size() != 0);
  endtask

  // Only called with the channels drained, so the shadow registers update right away
  task automatic write_reg(input bci_pkg::reg_idx_e idx,
                           input logic [bci_pkg::CodeW-1:0] data);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    if (idx == bci_pkg::REG_ERROR_CODE)
      code_q = (data > bci_pkg::CODE_MAX) ? bci_pkg::CODE_MAX : data;
    else en_q = data[0];
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Queue n advancing ticks with hold ticks mixed in, then drain
  task automatic queue_ticks(input int unsigned n_adv, input int unsigned hold_pct);
    int unsigned pushed;
    pushed = 0;
    while (pushed < n_adv) begin
      if ($urandom_range(99) < hold_pct) begin
        ms_ticks.push_back(1'b0);
      end else begin
        ms_ticks.push_back(1'b1);
        pushed++;
      end
    end
    wait_idle();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : drive_ticks
    bci_pkg::result_t owed;
    if (!rst_ni) begin
      tick_if.valid   <= 1'b0;
      tick_if.advance <= 1'b0;
      ph_q     = bci_pkg::PH_IDLE;
      ms_q     = '0;
      blinks_q = '0;
      lit_q    = 1'b0;
      tens_q   = '0;
      units_q  = '0;
    end else begin
      if (tick_if.valid && tick_if.ready) begin
        owed = next_indicator(tick_if.advance);
        due_results.push_back(owed);
      end
      if (!tick_if.valid || tick_if.ready) begin
        if (ms_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          tick_if.advance <= ms_ticks.pop_front();
          tick_if.valid   <= 1'b1;
        end else begin
          tick_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : check_results
    bci_pkg::result_t want;
    if (!rst_ni) begin
      led_if.ready <= 1'b0;
    end else begin
      if (led_if.valid && led_if.ready) begin
        if (due_results.size() == 0) begin
          report_mismatch("result transaction with no tick pending");
        end else begin
          want = due_results.pop_front();
          if (led_if.led_level !== want.led_level)
            report_mismatch($sformatf("result %0d: led_level %0b, expected %0b",
                                      checked_cnt, led_if.led_level, want.led_level));
          if (led_if.phase !== want.phase)
            report_mismatch($sformatf("result %0d: phase %0d, expected %0d",
                                      checked_cnt, led_if.phase, want.phase));
          if (led_if.repeat_done !== want.repeat_done)
            report_mismatch($sformatf("result %0d: repeat_done %0b, expected %0b",
                                      checked_cnt, led_if.repeat_done, want.repeat_done));
        end
        checked_cnt++;
      end
      led_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((tick_if.valid && tick_if.ready) || (led_if.valid && led_if.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("Testbench completed WITH ERRORS");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    cfg_we   = 1'b0;
    cfg_idx  = bci_pkg::REG_ERROR_CODE;
    cfg_data = '0;
    rst_ni   = 1'b0;
    code_q   = '0;
    en_q     = 1'b0;
    set_idling(29, 47);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Idle with enable clear: advancing and hold ticks leave the LED dark
    ms_ticks = '{1'b1, 1'b0, 1'b1};
    wait_idle();
    // Oversized code clamps to 99; still idle until enabled
    write_reg(bci_pkg::REG_ERROR_CODE, 7'h7F);
    ms_ticks = '{1'b1, 1'b1};
    wait_idle();
    // Zero tens digit: the first advancing tick goes straight to the digit gap
    write_reg(bci_pkg::REG_ERROR_CODE, 7'd1);
    write_reg(bci_pkg::REG_ENABLE, 7'h7F);
    ms_ticks = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
    wait_idle();

    // Rewrite the code inside the digit gap; the running repetition keeps its digits
    queue_ticks(200, 5);
    write_reg(bci_pkg::REG_ERROR_CODE, 7'h7F);
    set_idling(47, 29);
    // End of the digit gap, then the lit half of the single short blink
    queue_ticks(300, 5);

    set_idling(0, 0);
    // Clear enable mid-repetition: the dark half ends the units, then the code gap runs
    write_reg(bci_pkg::REG_ENABLE, 7'($urandom_range(63) << 1));
    queue_ticks(260, 5);

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/bci_pkg.sv
hw/rtl/bci_if.sv
hw/rtl/bci_cfg.sv
hw/rtl/bci_core.sv
hw/rtl/blink_code_error_indicator_top.sv
sim/tb_blink_code_error_indicator_top.sv
